// ===== design/tcds_pkg.sv =====
// ----------------------------------------------------------------------------
// tcds_pkg
// Shared types and constants for the table cell difference statistics block.
// ----------------------------------------------------------------------------
package tcds_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int MAX_CELLS_DEF = 65536;
    localparam int SUM_W         = 48;
    localparam int ALU_W         = SUM_W + 1;
    localparam int EPS_W         = 32;
    localparam int LEN_W         = 13;
    localparam int ROW_W         = 16;
    localparam int COL_W         = 12;
    localparam int CNT_OUT_W     = 17;
    localparam int DELTA_W       = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int MAX_ROW_LEN   = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_CHANGES = 2'd2;

    localparam logic REC_CHANGE  = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value_old;
        logic signed [VALUE_BITS-1:0] value_new;
        logic                         final_cell;
    } t_in_item;

    typedef struct packed {
        logic                         record_kind;
        logic [ROW_W-1:0]             row_index;
        logic [COL_W-1:0]             col_index;
        logic signed [VALUE_BITS-1:0] old_out;
        logic signed [VALUE_BITS-1:0] new_out;
        logic [CNT_OUT_W-1:0]         cells_total;
        logic [CNT_OUT_W-1:0]         cells_over_eps;
        logic [DELTA_W-1:0]           max_delta;
        logic [DELTA_W-1:0]           mean_delta;
        logic                         last_result;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB,
        ST_ABS,
        ST_EPS,
        ST_SUM,
        ST_MAX,
        ST_CHG,
        ST_DIV,
        ST_SUMMARY
    } t_state;

endpackage

// ===== design/table_cell_diff_stats.sv =====
// ----------------------------------------------------------------------------
// table_cell_diff_stats
// Thresholded cell difference of two tables with count, max and mean summary.
// ----------------------------------------------------------------------------
// Each accepted cell pair runs through one shared 49-bit add/subtract unit
// under a small sequencer: difference, absolute value, epsilon compare, sum
// accumulate and max compare, then an output step, so o_in_stall stays high
// through all of these steps and no new item is taken until the cell is done
// (the output step also waits while the change record is held off by
// i_out_stall). The final cell of a table adds a restoring division of the
// 48-bit change sum by the changed count on the same unit, one quotient bit
// per cycle, then a summary step that loads the summary item (waiting while
// it is held off by i_out_stall). o_in_stall is high while an item is in work.
// Configuration writes are always taken (o_cfg_ready is tied high) and
// should be made while idle.
module table_cell_diff_stats #(
    parameter int MAX_CELLS = tcds_pkg::MAX_CELLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tcds_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tcds_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tcds_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcds_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tcds_pkg::*;

    localparam int CNT_W   = $clog2(MAX_CELLS + 1);
    localparam int EXT_W   = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CELLS);
    localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};

    // configuration
    logic [EPS_W-1:0] r_epsilon;
    logic [LEN_W-1:0] r_row_length;
    logic             r_emit;

    // sequencer and item
    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_old, r_new;
    logic                    r_fin;
    logic [ALU_W-1:0]        r_diff;
    logic [DELTA_W-1:0]      r_ad;
    logic                    r_changed;

    // statistics
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CNT_W-1:0]  r_total, r_chg_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic [DELTA_W-1:0] r_max;

    // divider
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    // shared unit
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_sub;

    logic             in_acc, out_free, out_load;
    logic [CNT_W:0]   div_shift;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] col_next;
    logic [DELTA_W-1:0] mean_val;
    logic [EXT_W-1:0] total_ext, chg_ext;
    t_out_item        rec;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign alu_res   = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
    assign div_shift = {r_rem, r_quo[SUM_W-1]};

    always_comb begin
        if (r_row_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_row_length > LEN_W'(MAX_ROW_LEN)) begin
            len_eff = LEN_W'(MAX_ROW_LEN);
        end else begin
            len_eff = r_row_length;
        end
    end
    assign col_next = LEN_W'(r_col) + LEN_W'(1);

    always_comb begin
        if (r_chg_cnt == '0) begin
            mean_val = '0;
        end else if (r_quo[SUM_W-1:DELTA_W] != '0) begin
            mean_val = {DELTA_W{1'b1}};
        end else begin
            mean_val = r_quo[DELTA_W-1:0];
        end
    end
    assign total_ext = EXT_W'(r_total);
    assign chg_ext   = EXT_W'(r_chg_cnt);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (in_acc) n_state = ST_SUB;
            ST_SUB:     n_state = ST_ABS;
            ST_ABS:     n_state = ST_EPS;
            ST_EPS:     n_state = ST_SUM;
            ST_SUM:     n_state = ST_MAX;
            ST_MAX:     n_state = ST_CHG;
            ST_CHG: begin
                if (!(r_changed && r_emit) || out_free) begin
                    n_state = r_fin ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:     if (r_step == STEP_W'(SUM_W - 1)) n_state = ST_SUMMARY;
            ST_SUMMARY: if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // shared unit operands and output record
    always_comb begin
        alu_a    = '0;
        alu_b    = '0;
        alu_sub  = 1'b0;
        out_load = 1'b0;
        rec      = '0;
        case (r_state)
            ST_SUB: begin
                alu_a   = {{(ALU_W-VALUE_BITS){r_new[VALUE_BITS-1]}}, r_new};
                alu_b   = {{(ALU_W-VALUE_BITS){r_old[VALUE_BITS-1]}}, r_old};
                alu_sub = 1'b1;
            end
            ST_ABS: begin
                // negate when the difference came out negative
                alu_b   = r_diff;
                alu_sub = r_diff[ALU_W-1];
            end
            ST_EPS: begin
                alu_a   = ALU_W'(r_epsilon);
                alu_b   = ALU_W'(r_ad);
                alu_sub = 1'b1;
            end
            ST_SUM: begin
                alu_a = ALU_W'(r_sum);
                alu_b = ALU_W'(r_ad);
            end
            ST_MAX: begin
                alu_a   = ALU_W'(r_max);
                alu_b   = ALU_W'(r_ad);
                alu_sub = 1'b1;
            end
            ST_CHG: begin
                rec.record_kind = REC_CHANGE;
                rec.row_index   = r_row;
                rec.col_index   = r_col;
                rec.old_out     = r_old;
                rec.new_out     = r_new;
                out_load        = r_changed && r_emit && out_free;
            end
            ST_DIV: begin
                alu_a   = ALU_W'(div_shift);
                alu_b   = ALU_W'(r_chg_cnt);
                alu_sub = 1'b1;
            end
            ST_SUMMARY: begin
                rec.record_kind    = REC_SUMMARY;
                rec.cells_total    = total_ext[CNT_OUT_W-1:0];
                rec.cells_over_eps = chg_ext[CNT_OUT_W-1:0];
                rec.max_delta      = r_max;
                rec.mean_delta     = mean_val;
                rec.last_result    = 1'b1;
                out_load           = out_free;
            end
            default: begin
            end
        endcase
        if (r_state == ST_CHG) begin
            rec.last_result = !r_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_epsilon    <= '0;
            r_row_length <= LEN_W'(1);
            r_emit       <= 1'b1;
            r_col        <= '0;
            r_row        <= '0;
            r_total      <= '0;
            r_chg_cnt    <= '0;
            r_sum        <= '0;
            r_max        <= '0;
            r_out_valid  <= 1'b0;
            r_step       <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EPSILON:      r_epsilon    <= i_cfg_data[EPS_W-1:0];
                    CFG_ROW_LENGTH:   r_row_length <= i_cfg_data[LEN_W-1:0];
                    CFG_EMIT_CHANGES: r_emit       <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_SUB: begin
                    if (r_total < CNT_MAX) r_total <= r_total + CNT_W'(1);
                end
                ST_SUM: begin
                    if (r_changed) begin
                        if (r_chg_cnt < CNT_MAX) r_chg_cnt <= r_chg_cnt + CNT_W'(1);
                        r_sum <= alu_res[ALU_W-1] ? SUM_SAT : alu_res[SUM_W-1:0];
                    end
                end
                ST_MAX: begin
                    if (r_changed && alu_res[ALU_W-1]) r_max <= r_ad;
                end
                ST_CHG: begin
                    if (n_state != ST_CHG) begin
                        // advance the cell position
                        if (col_next >= len_eff) begin
                            r_col <= '0;
                            r_row <= r_row + ROW_W'(1);
                        end else begin
                            r_col <= col_next[COL_W-1:0];
                        end
                        r_step <= '0;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                end
                ST_SUMMARY: begin
                    if (out_load) begin
                        r_col     <= '0;
                        r_row     <= '0;
                        r_total   <= '0;
                        r_chg_cnt <= '0;
                        r_sum     <= '0;
                        r_max     <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_old <= i_in.value_old;
            r_new <= i_in.value_new;
            r_fin <= i_in.final_cell;
        end
        case (r_state)
            ST_SUB: r_diff <= alu_res;
            ST_ABS: r_ad   <= alu_res[DELTA_W-1:0];
            ST_EPS: r_changed <= alu_res[ALU_W-1];
            ST_CHG: begin
                r_quo <= r_sum;
                r_rem <= '0;
            end
            ST_DIV: begin
                // restoring step: keep the trial remainder when it did not borrow
                if (alu_res[ALU_W-1]) begin
                    r_rem <= div_shift[CNT_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                end else begin
                    r_rem <= alu_res[CNT_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out <= rec;
        end
    end

endmodule
